>>> rtl/core/assert_macros.svh
// Assertion macros used by the checker file of the sharpen filter.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent check, suspended while reset is high
`define SH3_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Concurrent check that also runs through reset
`define SH3_ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> rtl/core/sh3_pkg.sv
// Shared types and constants of the 3x3 sharpen filter.
package sh3_pkg;

   // Default sizes of the line stores
   localparam int MAX_WIDTH_DEF    = 2048;
   localparam int MAX_CHANNELS_DEF = 4;

   // Field and register widths
   localparam int SAMPLE_W   = 8;
   localparam int IMG_W_W    = 12;
   localparam int IMG_H_W    = 16;
   localparam int CHAN_W     = 3;
   localparam int ROW_W      = IMG_H_W + 1;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 16;

   // Reset values of the registers
   localparam logic [IMG_W_W-1:0] IMG_W_RESET = 12'd640;
   localparam logic [IMG_H_W-1:0] IMG_H_RESET = 16'd480;
   localparam logic [CHAN_W-1:0]  CHAN_RESET  = 3'd1;

   // Result queue
   localparam int QUEUE_DEPTH = 4;
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   typedef logic [SAMPLE_W-1:0] sample_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_WIDTH    = 2'd0,
      CSR_HEIGHT   = 2'd1,
      CSR_CHANNELS = 2'd2
   } csr_idx_type;

   typedef enum logic {
      KIND_SAMPLE = 1'b0,
      KIND_FLUSH  = 1'b1
   } kind_type;

   // What a beat in flight will produce
   typedef struct packed {
      logic emit;
      logic zero;
      logic last;
   } res_ctl_type;

   // Commands to the window taps
   typedef struct packed {
      logic shift;
      logic restart;
      logic clear;
   } tap_cmd_type;

   // One result beat
   typedef struct packed {
      sample_type value;
      logic       last;
   } res_type;

endpackage

>>> rtl/core/sh3_line_store.sv
// Two line stores (row above and middle row) with registered reads.
module sh3_line_store #(
   parameter int LINE_DEPTH = sh3_pkg::MAX_WIDTH_DEF * sh3_pkg::MAX_CHANNELS_DEF,
   parameter int ADDR_W     = $clog2(LINE_DEPTH)
) (
   input  logic                clock,
   input  logic                rd_en,
   input  logic [ADDR_W-1:0]   rd_addr,
   input  logic                wr_en,
   input  logic [ADDR_W-1:0]   wr_addr,
   input  sh3_pkg::sample_type wr_sample,
   output sh3_pkg::sample_type top_q,
   output sh3_pkg::sample_type mid_q
);
   import sh3_pkg::*;

   sample_type above_mem  [LINE_DEPTH];
   sample_type middle_mem [LINE_DEPTH];
   sample_type top_ff;
   sample_type mid_ff;

   // Read both rows at the column of the new beat
   always_ff @(posedge clock) begin
      if (rd_en) begin
         top_ff <= above_mem[rd_addr];
         mid_ff <= middle_mem[rd_addr];
      end
   end

   // Write back in the cycle after the read: middle row moves up, new sample goes in.
   // Consecutive beats hit different columns, so no forwarding is needed.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         above_mem[wr_addr]  <= mid_ff;
         middle_mem[wr_addr] <= wr_sample;
      end
   end

   assign top_q = top_ff;
   assign mid_q = mid_ff;

endmodule

>>> rtl/core/sh3_window.sv
// Three-row window of recent samples and the sharpen arithmetic.
module sh3_window #(
   parameter int MAX_CHANNELS = sh3_pkg::MAX_CHANNELS_DEF
) (
   input  logic                         clock,
   input  logic                         reset,
   input  sh3_pkg::tap_cmd_type         cmd,
   input  sh3_pkg::sample_type          top,
   input  sh3_pkg::sample_type          mid,
   input  sh3_pkg::sample_type          sample,
   input  logic [sh3_pkg::CHAN_W-1:0]   chan,
   input  logic                         zero,
   output sh3_pkg::sample_type          value
);
   import sh3_pkg::*;

   localparam int TAP_COLS = 2 * MAX_CHANNELS + 1;

   logic [2:0][TAP_COLS-1:0][SAMPLE_W-1:0] taps_ff;
   logic [2:0][TAP_COLS-1:0][SAMPLE_W-1:0] taps_in;

   sample_type        centre;
   sample_type        left_s;
   sample_type        right_s;
   sample_type        up_s;
   sample_type        down_s;
   logic [10:0]       five_c;
   logic [9:0]        neigh;
   logic signed [11:0] diff;

   // Clear or shift the taps; on a shift column 0 takes the newest top, middle and bottom samples
   always_comb begin
      taps_in = taps_ff;
      if (cmd.clear) begin
         taps_in = '0;
      end else if (cmd.shift) begin
         for (int r = 0; r < 3; r++) begin
            for (int j = TAP_COLS - 1; j > 0; j--) begin
               taps_in[r][j] = cmd.restart ? '0 : taps_ff[r][j-1];
            end
         end
         taps_in[0][0] = top;
         taps_in[1][0] = mid;
         taps_in[2][0] = sample;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         taps_ff <= '0;
      end else begin
         taps_ff <= taps_in;
      end
   end

   // Neighbours of the same channel sit one pixel (chan taps) apart
   always_comb begin
      centre = '0;
      left_s = '0;
      up_s   = '0;
      down_s = '0;
      for (int m = 1; m <= MAX_CHANNELS; m++) begin
         if (int'(chan) == m) begin
            centre = taps_ff[1][m];
            left_s = taps_ff[1][2*m];
            up_s   = taps_ff[0][m];
            down_s = taps_ff[2][m];
         end
      end
   end

   assign right_s = taps_ff[1][0];

   // 5*centre minus the four neighbours, saturated to 0..255
   assign five_c = {1'b0, centre, 2'b00} + {3'b000, centre};
   assign neigh  = {2'b00, left_s} + {2'b00, right_s} + {2'b00, up_s} + {2'b00, down_s};
   assign diff   = $signed({1'b0, five_c}) - $signed({2'b00, neigh});

   always_comb begin
      if (zero || diff < 12'sd0) begin
         value = '0;
      end else if (diff > 12'sd255) begin
         value = 8'd255;
      end else begin
         value = diff[SAMPLE_W-1:0];
      end
   end

endmodule

>>> rtl/core/sh3_out_queue.sv
// Small result queue that decouples the pipeline from the output handshake.
module sh3_out_queue #(
   parameter int DEPTH = sh3_pkg::QUEUE_DEPTH
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        push,
   input  sh3_pkg::res_type            push_data,
   input  logic                        pop,
   output logic                        head_valid,
   output sh3_pkg::res_type            head,
   output logic [$clog2(DEPTH+1)-1:0]  count
);
   import sh3_pkg::*;

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   res_type            slot_ff [DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff;
   logic [PTR_W-1:0]   wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff;
   logic [PTR_W-1:0]   rd_ptr_in;
   logic [CNT_W-1:0]   cnt_ff;
   logic [CNT_W-1:0]   cnt_in;

   // Pointer and fill level update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      cnt_in    = cnt_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (pop && !push) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   // Payload slots
   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

   assign head_valid = (cnt_ff != '0);
   assign head       = slot_ff[rd_ptr_ff];
   assign count      = cnt_ff;

endmodule

>>> rtl/core/sharpen_3x3_stream.sv
// Top level of the streaming 3x3 Laplacian sharpen filter. Samples enter in
// raster order, channels interleaved, one beat per clock sustained while the
// output takes results; each sample beat past the first line plus one pixel
// gives one result beat of 5*centre minus its four same-channel neighbours,
// saturated, and zero on the frame border. After the last sample, flush beats
// drain the pending border results; the final one carries last_of_frame. A
// result passes the line store read, the window shift and the arithmetic into
// the queue before it is presented. The four-entry result queue lets input
// keep flowing while results wait. The two line stores are single-write,
// single-read memories hit once per sample beat; their contents after reset
// are not cleared, as unwritten columns only ever feed border results, so
// there is no start-up clearing pass. Input is not accepted while reset is
// high. A register write restarts the frame and must be done while the block
// is idle.
module sharpen_3x3_stream #(
   parameter int MAX_WIDTH    = sh3_pkg::MAX_WIDTH_DEF,
   parameter int MAX_CHANNELS = sh3_pkg::MAX_CHANNELS_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  logic                            req_kind,
   input  logic [sh3_pkg::SAMPLE_W-1:0]    req_sample,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output logic [sh3_pkg::SAMPLE_W-1:0]    rsp_value,
   output logic                            rsp_last_of_frame,
   input  logic                            csr_we,
   input  logic [sh3_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [sh3_pkg::CSR_DATA_W-1:0]  csr_wdata
);
   import sh3_pkg::*;

   localparam int LINE_DEPTH = MAX_WIDTH * MAX_CHANNELS;
   localparam int K_W        = $clog2(LINE_DEPTH);
   localparam int CH_W       = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;

   // Configuration registers
   logic [IMG_W_W-1:0] width_ff, width_in;
   logic [IMG_H_W-1:0] height_ff, height_in;
   logic [CHAN_W-1:0]  chan_ff, chan_in;
   logic               cfg_hit;

   logic [IMG_W_W-1:0] w_eff;
   logic [IMG_H_W-1:0] h_eff;
   logic [CHAN_W-1:0]  c_eff;

   // Input and output position counters
   logic [IMG_W_W-1:0] in_col_ff, in_col_in;
   logic [CH_W-1:0]    in_ch_ff, in_ch_in;
   logic [K_W-1:0]     in_k_ff, in_k_in;
   logic [ROW_W-1:0]   in_row_ff, in_row_in;
   logic [IMG_W_W-1:0] out_col_ff, out_col_in;
   logic [CH_W-1:0]    out_ch_ff, out_ch_in;
   logic [ROW_W-1:0]   out_row_ff, out_row_in;

   // Beat decode
   logic               accept;
   logic               is_flush;
   logic               in_done;
   logic               out_done;
   logic               restart;
   logic [ROW_W-1:0]   row_cur;
   logic [IMG_W_W-1:0] ocol_cur;
   logic [CH_W-1:0]    och_cur;
   logic [ROW_W-1:0]   orow_cur;
   logic               past_lag;
   logic               in_ch_end;
   logic               in_row_end;
   logic               out_ch_end;
   logic               out_col_end;
   logic               border;
   res_ctl_type        s0_ctl;

   // Pipeline stages
   logic               s1_valid_ff;
   res_ctl_type        s1_ctl_ff;
   logic               s1_sample_beat_ff;
   logic               s1_restart_ff;
   logic [K_W-1:0]     s1_k_ff;
   sample_type         s1_sample_ff;
   logic               s2_valid_ff;
   res_ctl_type        s2_ctl_ff;

   sample_type         top_q;
   sample_type         mid_q;
   tap_cmd_type        tap_cmd;
   sample_type         win_value;
   res_type            push_data;
   res_type            head;
   logic               head_valid;
   logic [QCNT_W-1:0]  q_count;
   logic               push;
   logic               pop;

   // Register writes
   always_comb begin
      width_in  = width_ff;
      height_in = height_ff;
      chan_in   = chan_ff;
      cfg_hit   = 1'b0;
      if (csr_we) begin
         case (csr_idx_type'(csr_index))
            CSR_WIDTH: begin
               width_in = csr_wdata[IMG_W_W-1:0];
               cfg_hit  = 1'b1;
            end
            CSR_HEIGHT: begin
               height_in = csr_wdata[IMG_H_W-1:0];
               cfg_hit   = 1'b1;
            end
            CSR_CHANNELS: begin
               chan_in = csr_wdata[CHAN_W-1:0];
               cfg_hit = 1'b1;
            end
            default: begin
               cfg_hit = 1'b0;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= IMG_W_RESET;
         height_ff <= IMG_H_RESET;
         chan_ff   <= CHAN_RESET;
      end else begin
         width_ff  <= width_in;
         height_ff <= height_in;
         chan_ff   <= chan_in;
      end
   end

   // Clamped geometry
   always_comb begin
      if (width_ff < 12'd3) begin
         w_eff = 12'd3;
      end else if (int'(width_ff) > MAX_WIDTH) begin
         w_eff = IMG_W_W'(MAX_WIDTH);
      end else begin
         w_eff = width_ff;
      end
      h_eff = (height_ff < 16'd3) ? 16'd3 : height_ff;
      if (chan_ff == '0) begin
         c_eff = 3'd1;
      end else if (int'(chan_ff) > MAX_CHANNELS) begin
         c_eff = CHAN_W'(MAX_CHANNELS);
      end else begin
         c_eff = chan_ff;
      end
   end

   // Decode of the beat at the input
   assign accept   = req_valid && req_ready;
   assign is_flush = (kind_type'(req_kind) == KIND_FLUSH);
   assign in_done  = (in_row_ff == {1'b0, h_eff});
   assign out_done = (out_row_ff == {1'b0, h_eff});
   assign restart  = !is_flush && in_done;

   assign row_cur  = restart ? '0 : in_row_ff;
   assign ocol_cur = restart ? '0 : out_col_ff;
   assign och_cur  = restart ? '0 : out_ch_ff;
   assign orow_cur = restart ? '0 : out_row_ff;

   // Results start one line plus one pixel into the frame
   assign past_lag   = (row_cur >= ROW_W'(2)) ||
                       ((row_cur == ROW_W'(1)) && (int'(in_k_ff) >= int'(c_eff)));
   assign in_ch_end  = (int'(in_ch_ff) == int'(c_eff) - 1);
   assign in_row_end = in_ch_end && (in_col_ff == w_eff - 12'd1);
   assign out_ch_end  = (int'(och_cur) == int'(c_eff) - 1);
   assign out_col_end = (ocol_cur == w_eff - 12'd1);

   assign border = (orow_cur == '0) || (orow_cur >= {1'b0, h_eff - 16'd1}) ||
                   (ocol_cur == '0) || (ocol_cur >= w_eff - 12'd1);

   always_comb begin
      s0_ctl.emit = is_flush ? (in_done && !out_done) : past_lag;
      s0_ctl.zero = is_flush || border;
      s0_ctl.last = (orow_cur == {1'b0, h_eff - 16'd1}) && out_col_end && out_ch_end;
   end

   // Position counters
   always_comb begin
      in_col_in  = in_col_ff;
      in_ch_in   = in_ch_ff;
      in_k_in    = in_k_ff;
      in_row_in  = in_row_ff;
      out_col_in = out_col_ff;
      out_ch_in  = out_ch_ff;
      out_row_in = out_row_ff;
      if (cfg_hit) begin
         in_col_in  = '0;
         in_ch_in   = '0;
         in_k_in    = '0;
         in_row_in  = '0;
         out_col_in = '0;
         out_ch_in  = '0;
         out_row_in = '0;
      end else if (accept) begin
         if (!is_flush) begin
            in_ch_in  = in_ch_end ? '0 : in_ch_ff + 1'b1;
            in_k_in   = in_row_end ? '0 : in_k_ff + 1'b1;
            in_row_in = in_row_end ? row_cur + 1'b1 : row_cur;
            if (in_ch_end) begin
               in_col_in = in_row_end ? '0 : in_col_ff + 1'b1;
            end
         end
         if (s0_ctl.emit) begin
            out_ch_in  = out_ch_end ? '0 : och_cur + 1'b1;
            out_col_in = ocol_cur;
            out_row_in = orow_cur;
            if (out_ch_end) begin
               out_col_in = out_col_end ? '0 : ocol_cur + 1'b1;
               out_row_in = out_col_end ? orow_cur + 1'b1 : orow_cur;
            end
         end else if (restart) begin
            out_col_in = '0;
            out_ch_in  = '0;
            out_row_in = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_col_ff  <= '0;
         in_ch_ff   <= '0;
         in_k_ff    <= '0;
         in_row_ff  <= '0;
         out_col_ff <= '0;
         out_ch_ff  <= '0;
         out_row_ff <= '0;
      end else begin
         in_col_ff  <= in_col_in;
         in_ch_ff   <= in_ch_in;
         in_k_ff    <= in_k_in;
         in_row_ff  <= in_row_in;
         out_col_ff <= out_col_in;
         out_ch_ff  <= out_ch_in;
         out_row_ff <= out_row_in;
      end
   end

   // Stage valids and control
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s1_ctl_ff   <= '0;
         s2_valid_ff <= 1'b0;
         s2_ctl_ff   <= '0;
      end else begin
         s1_valid_ff <= accept;
         s1_ctl_ff   <= accept ? s0_ctl : '0;
         s2_valid_ff <= s1_valid_ff;
         s2_ctl_ff   <= s1_ctl_ff;
      end
   end

   // Stage 1 payload
   always_ff @(posedge clock) begin
      if (accept) begin
         s1_sample_beat_ff <= !is_flush;
         s1_restart_ff     <= restart;
         s1_k_ff           <= in_k_ff;
         s1_sample_ff      <= req_sample;
      end
   end

   // Line stores: read at the input, write back in stage 1
   sh3_line_store #(
      .LINE_DEPTH (LINE_DEPTH)
   ) u_line_store (
      .clock     (clock),
      .rd_en     (accept && !is_flush),
      .rd_addr   (in_k_ff),
      .wr_en     (s1_valid_ff && s1_sample_beat_ff),
      .wr_addr   (s1_k_ff),
      .wr_sample (s1_sample_ff),
      .top_q     (top_q),
      .mid_q     (mid_q)
   );

   // Window shifts in stage 1, arithmetic in stage 2
   always_comb begin
      tap_cmd.shift   = s1_valid_ff && s1_sample_beat_ff;
      tap_cmd.restart = s1_restart_ff;
      tap_cmd.clear   = cfg_hit;
   end

   sh3_window #(
      .MAX_CHANNELS (MAX_CHANNELS)
   ) u_window (
      .clock  (clock),
      .reset  (reset),
      .cmd    (tap_cmd),
      .top    (top_q),
      .mid    (mid_q),
      .sample (s1_sample_ff),
      .chan   (c_eff),
      .zero   (s2_ctl_ff.zero),
      .value  (win_value)
   );

   // Result queue; input is held back while reset is high or when every slot is spoken for
   assign push            = s2_valid_ff && s2_ctl_ff.emit;
   assign push_data.value = win_value;
   assign push_data.last  = s2_ctl_ff.last;
   assign pop             = head_valid && rsp_ready;

   sh3_out_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_out_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_data  (push_data),
      .pop        (pop),
      .head_valid (head_valid),
      .head       (head),
      .count      (q_count)
   );

   assign req_ready = !reset &&
                      ((int'(q_count) + int'(s1_ctl_ff.emit) + int'(push)) < QUEUE_DEPTH);

   assign rsp_valid         = head_valid;
   assign rsp_value         = head.value;
   assign rsp_last_of_frame = head.last;

endmodule

>>> rtl/core/sh3_checker.sv
// Port-level checks of the sharpen filter and their binding to the top level.
`include "assert_macros.svh"

module sh3_checker (
   input logic                          clock,
   input logic                          reset,
   input logic                          rsp_valid,
   input logic                          rsp_ready,
   input logic [sh3_pkg::SAMPLE_W-1:0]  rsp_value,
   input logic                          rsp_last_of_frame
);
   import sh3_pkg::*;

   // Nothing is pending straight after reset
   `SH3_ASSERT_ALWAYS(a_quiet_after_reset, clock, reset |=> !rsp_valid, "result beat right after reset")

   // An input beat accepted after reset passes both stage registers and the queue before it can reach the output
   `SH3_ASSERT(a_pipe_latency, clock, reset, $past(reset, 2) |-> !rsp_valid, "result beat too early after reset")

   // A stalled result beat holds
   `SH3_ASSERT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_value) && $stable(rsp_last_of_frame), "stalled result beat changed")

   // The final sample of a frame lies on the border, so it is zero
   `SH3_ASSERT(a_last_is_border, clock, reset, rsp_valid && rsp_last_of_frame |-> rsp_value == '0, "last beat of frame not zero")

endmodule

bind sharpen_3x3_stream sh3_checker u_sh3_checker (
   .clock             (clock),
   .reset             (reset),
   .rsp_valid         (rsp_valid),
   .rsp_ready         (rsp_ready),
   .rsp_value         (rsp_value),
   .rsp_last_of_frame (rsp_last_of_frame)
);
